// File: hw/rtl/bb3_pkg.sv
// bb3_pkg: shared types, constants and helpers for the 3x3 box blur.
// Used by bb3_ctrl, bb3_datapath and box_blur_3x3_clamped. No dependencies.
package bb3_pkg;

  // Default frame limits, handed down as parameters from the top level
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register map and geometry
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

  // Datapath widths
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 12;  // 9 * 255 fits
  localparam int CNT_W   = 4;   // up to 9 neighbours
  localparam int RECIP_W = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Input kind codes
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input word accepted this cycle
    logic read_en;   // issue one neighbour read and step the tap counter
    logic mul_en;    // register sum times reciprocal
    logic load_out;  // move the quotient into the output register
  } bb3_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;      // the word on the input side gives a result
    logic tap_last;  // the read being issued is the ninth
    logic out_free;  // output register can take a new word
  } bb3_status_t;

  // ceil(2^16 / n): floor(s * recip(n) / 2^16) == floor(s / n) for s < 4096
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/bb3_ctrl.sv
// bb3_ctrl: sequencer for the box blur; one result at a time.
// Depends on bb3_pkg; drives bb3_datapath through bb3_cmd_t.
module bb3_ctrl
  import bb3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bb3_status_t status,
  output bb3_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.take     = in_valid && in_ready;
    cmd.read_en  = (state == S_READ);
    cmd.mul_en   = (state == S_MUL);
    cmd.load_out = (state == S_DONE) && status.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.take && status.emit) state_next = S_READ;
      S_READ: if (status.tap_last) state_next = S_ACC;
      S_ACC:  state_next = S_MUL;
      S_MUL:  state_next = S_DONE;
      S_DONE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/bb3_datapath.sv
// bb3_datapath: line memory, frame position counters, neighbour sum and
// reciprocal divide, output register. Depends on bb3_pkg; driven by bb3_ctrl.
module bb3_datapath
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  kind,
  input  logic [PIX_W-1:0]      pixel,
  input  bb3_cmd_t              cmd,
  output bb3_status_t           status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_blurred,
  output logic                  out_last
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = COL_W + 2;
  localparam int DEPTH  = 1 << ADDR_W;

  // Configuration registers
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [WID_W-1:0]      uw;
  logic [ROW_W-1:0]      uh;

  // Positions
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             cur_last;

  // Neighbour walk
  logic [1:0]       ty;
  logic [1:0]       tx;
  logic [CNT_W-1:0] tap_count;
  logic [SUM_W-1:0] sum;
  logic             rd_pend;
  logic [PIX_W-1:0] mem_q;
  logic [PROD_W-1:0] prod;

  logic [PIX_W-1:0] line_mem [DEPTH];

  logic complete, is_pix, early, emit_last, in_frame, col_wrap;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [1:0]        rd_slot;
  logic [COL_W-1:0]  rd_col;

  // Registers in use, clamped to [1, MAX]
  always_comb begin
    if (frame_width == '0) begin
      uw = WID_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      uw = WID_W'(MAX_WIDTH);
    end else begin
      uw = WID_W'(frame_width);
    end
    if (frame_height == '0) begin
      uh = ROW_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      uh = ROW_W'(MAX_HEIGHT);
    end else begin
      uh = ROW_W'(frame_height);
    end
  end

  // Decision for the word on the input side
  assign complete  = (in_row == uh);
  assign is_pix    = (kind == KIND_PIXEL);
  assign early     = (32'(in_row) >= 2) || ((32'(in_row) == 1) && (in_column != '0));
  assign emit_last = (32'(out_row) + 1 == 32'(uh)) && (32'(out_col) + 1 == 32'(uw));
  assign col_wrap  = (32'(in_column) + 1 == 32'(uw));
  assign wr_addr   = {2'(in_row), in_column};

  assign status.emit     = complete || (is_pix && early);
  assign status.tap_last = (ty == 2'd2) && (tx == 2'd2);
  assign status.out_free = !out_valid || out_ready;

  // Neighbour address and in-frame test for tap (ty, tx), offsets ty-1, tx-1
  always_comb begin
    in_frame = 1'b1;
    if (ty == 2'd0 && cur_row == '0) in_frame = 1'b0;
    if (ty == 2'd2 && 32'(cur_row) + 1 == 32'(uh)) in_frame = 1'b0;
    if (tx == 2'd0 && cur_col == '0) in_frame = 1'b0;
    if (tx == 2'd2 && 32'(cur_col) + 1 == 32'(uw)) in_frame = 1'b0;
    rd_slot = 2'(cur_row) + ty - 2'd1;
    rd_col  = cur_col + COL_W'(tx) - COL_W'(1);
    rd_addr = {rd_slot, rd_col};
  end

  // Configuration and frame positions
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      in_column    <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
        in_column <= '0;
        in_row    <= '0;
        out_col   <= '0;
        out_row   <= '0;
      end
    end else if (cmd.take) begin
      if (!complete && is_pix) begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + ROW_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
      end
      if (status.emit) begin
        if (emit_last) begin
          in_column <= '0;
          in_row    <= '0;
          out_col   <= '0;
          out_row   <= '0;
        end else if (32'(out_col) + 1 == 32'(uw)) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Position of the result being worked out
  always_ff @(posedge clk) begin
    if (cmd.take && status.emit) begin
      cur_row  <= out_row;
      cur_col  <= out_col;
      cur_last <= emit_last;
    end
  end

  // Line memory: four rows, write on pixel words, one read per cycle while read_en is set
  always_ff @(posedge clk) begin
    if (cmd.take && !complete && is_pix) begin
      line_mem[wr_addr] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      mem_q <= line_mem[rd_addr];
    end
  end

  // Tap walk and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      ty        <= '0;
      tx        <= '0;
      tap_count <= '0;
      sum       <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.take) begin
      ty        <= '0;
      tx        <= '0;
      tap_count <= '0;
      sum       <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= cmd.read_en && in_frame;
      if (rd_pend) sum <= sum + SUM_W'(mem_q);
      if (cmd.read_en) begin
        if (in_frame) tap_count <= tap_count + CNT_W'(1);
        if (tx == 2'd2) begin
          tx <= '0;
          ty <= ty + 2'd1;
        end else begin
          tx <= tx + 2'd1;
        end
      end
    end
  end

  // Divide by the neighbour count through its reciprocal
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(sum) * PROD_W'(recip(tap_count));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_blurred <= prod[RECIP_SHIFT +: PIX_W];
      out_last    <= cur_last;
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    tap_count <= CNT_W'(9))
    else $error("neighbour count above nine");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output word overwritten before it was taken");

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.mul_en) |-> (prod[PROD_W-1:RECIP_SHIFT+PIX_W] == '0))
    else $error("quotient wider than a pixel");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.emit && emit_last && !cfg_we) |=>
      (in_row == '0 && in_column == '0 && out_row == '0 && out_col == '0))
    else $error("positions not cleared after the last result of a frame");

endmodule

// File: hw/rtl/box_blur_3x3_clamped.sv
// box_blur_3x3_clamped: top level of the 3x3 mean filter.
// Depends on bb3_pkg; instantiates bb3_ctrl and bb3_datapath.
//
// Usage:
//   s_axis carries input words: tdata = pixel, tuser = kind (0 pixel,
//   1 drain tick). m_axis carries results: tdata = blurred mean,
//   tlast = frame end. Pixels arrive in raster order; the result for
//   position p comes once pixel p + width + 1 is in, the rest of the frame
//   is pushed out by drain ticks (or surplus pixels) after the last pixel.
//   cfg_we / cfg_index / cfg_data write frame_width (0) and frame_height (1);
//   values are clamped to [1, MAX]. A write restarts the frame.
// Sequence:
//   A word that gives no result leaves the sequencer ready for the next
//   word. For a word that gives a result, the nine neighbours are read
//   one per cycle from the single read port of the line memory, then
//   come one accumulate, one multiply by the reciprocal of the count and
//   one load of the output register, which waits until it is free.
// Reset: clears positions and control, registers go to 1024. The line
//   memory is not cleared; only pixels of the current frame are ever summed.
// Stall: the output register holds a finished word while the receiver
//   stalls, and the next input word is accepted meanwhile.
module box_blur_3x3_clamped
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
  input  logic                  s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] blurred
  output logic                  m_axis_tlast    // frame_end
);

  bb3_cmd_t    cmd;
  bb3_status_t status;

  // Sequencer
  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Memory, counters and arithmetic
  bb3_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (s_axis_tuser),
    .pixel       (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_blurred (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule
